// File: sv/cfee_pkg.sv
// Shared types and constants for the centered FIR edge extrapolation unit.
`default_nettype none
package cfee_pkg;

  localparam int CNT_W    = 16;
  localparam int TAPCNT_W = 6;
  localparam int TAP_W    = 16;
  localparam int FRAC_W   = 15;
  localparam int RES_W    = 24;
  localparam int M_W      = 7;
  localparam int POS_W    = 17;
  localparam int TIDX_W   = 5;

  typedef enum logic [1:0] {
    KIND_HEAD,
    KIND_MID,
    KIND_TAIL
  } kind_e;

  typedef enum logic {
    CMD_TAP    = 1'b0,
    CMD_SAMPLE = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_TAIL,
    ST_MAC,
    ST_DRAIN,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic              tap_we;
    logic              sample_we;
    logic              clear_acc;
    logic              issue;
    logic [M_W-1:0]    k;
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic [M_W-1:0]    m;
    logic [M_W-1:0]    h2;
    logic [CNT_W-1:0]  s;
    logic              sat;
    logic              load_out;
    logic              out_zero;
    logic              out_last;
    logic              out_err;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/cfee_datapath.sv
// Datapath: tap and sample memories, edge extrapolation, MAC pipeline, output register.
`default_nettype none
module cfee_datapath #(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cfee_pkg::cmd_t                       cmd_i,
  input  wire logic signed [cfee_pkg::TAP_W-1:0]    tap_value_i,
  input  wire logic [cfee_pkg::TIDX_W-1:0]          tap_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_im_i,
  output logic                                      pipe_busy_o,
  output logic signed [cfee_pkg::RES_W-1:0]         result_re_o,
  output logic signed [cfee_pkg::RES_W-1:0]         result_im_o,
  output logic                                      last_result_o,
  output logic                                      error_short_o
);
  import cfee_pkg::*;

  localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int WAW = $clog2(MAX_TAPS + 1);
  localparam int WD  = 1 << WAW;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = $clog2(MAX_TAPS + 1);
  localparam int VW  = SW + CW + 3;
  localparam int PW  = VW + TAP_W;
  localparam int AW  = PW + TAW + 1;
  localparam int AGW = POS_W + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_W - 1);
  localparam logic signed [AW-1:0] RMAX = (AW'(1) << (RES_W - 1)) - AW'(1);
  localparam logic signed [AW-1:0] RMIN = -(AW'(1) << (RES_W - 1));

  function automatic logic signed [RES_W-1:0] round_sat(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] r;
    t = a + HALF;
    r = t >>> FRAC_W;
    if (r > RMAX) begin
      r = RMAX;
    end else if (r < RMIN) begin
      r = RMIN;
    end
    return r[RES_W-1:0];
  endfunction

  logic signed [TAP_W-1:0] tap_mem [MAX_TAPS];
  logic [2*SW-1:0]         win_mem [WD];
  logic [WAW-1:0]          wptr_q;
  logic [2*SW-1:0]         x0_q, x1_q, age0_q, age1_q;

  logic [POS_W:0]  q;
  logic            head_edge, tail_edge, age_ok;
  logic [AGW-1:0]  age;
  logic [POS_W:0]  c0_wide;
  logic [WAW-1:0]  raddr;

  logic                    v1_q, v2_q, v3_q;
  logic                    eh_q, et_q, ok_q;
  logic [CW-1:0]           c0_q;
  logic [2*SW-1:0]         win_rd_q;
  logic signed [TAP_W-1:0] tap_rd_q, tap2_q;

  logic signed [SW-1:0] a_re, a_im, b_re, b_im, w_re, w_im;
  logic signed [SW:0]   d_re, d_im;
  logic signed [CW:0]   c0s;
  logic signed [VW-1:0] e_re, e_im, v_re, v_im;
  logic signed [VW-1:0] v_re_q, v_im_q;
  logic signed [PW-1:0] p_re_q, p_im_q;
  logic signed [AW-1:0] acc_re_q, acc_im_q;

  logic signed [RES_W-1:0] res_re_q, res_im_q;
  logic                    res_last_q, res_err_q;

  // address generation
  always_comb begin
    q         = {1'b0, cmd_i.pos} + (POS_W+1)'(cmd_i.k);
    head_edge = (cmd_i.kind == KIND_HEAD) && (q < (POS_W+1)'(cmd_i.h2));
    tail_edge = (cmd_i.kind == KIND_TAIL) && (q >= (POS_W+1)'(cmd_i.m) - (POS_W+1)'(1));
    case (cmd_i.kind)
      KIND_HEAD: age = AGW'(cmd_i.s) + AGW'(cmd_i.h2) - AGW'(q);
      KIND_MID:  age = AGW'(cmd_i.pos) + AGW'(cmd_i.m) - AGW'(1) - AGW'(cmd_i.k);
      KIND_TAIL: age = AGW'(cmd_i.m) - AGW'(2) - AGW'(q);
      default:   age = '0;
    endcase
    age_ok = !age[AGW-1] && (age <= AGW'(MAX_TAPS)) && (cmd_i.sat || age <= AGW'(cmd_i.s));
    if (head_edge) begin
      c0_wide = (POS_W+1)'(cmd_i.h2) + (POS_W+1)'(1) - q;
    end else begin
      c0_wide = q + (POS_W+1)'(1) - (POS_W+1)'(cmd_i.h2);
    end
    raddr = wptr_q - age[WAW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we && (32'(tap_index_i) < MAX_TAPS)) begin
      tap_mem[TAW'(tap_index_i)] <= tap_value_i;
    end
    if (cmd_i.sample_we) begin
      win_mem[wptr_q + WAW'(1)] <= {sample_re_i, sample_im_i};
    end
    if (cmd_i.issue) begin
      win_rd_q <= win_mem[raddr];
      tap_rd_q <= tap_mem[cmd_i.k[TAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (cmd_i.sample_we) begin
        wptr_q <= wptr_q + WAW'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_we) begin
      age1_q <= age0_q;
      age0_q <= {sample_re_i, sample_im_i};
      if (!cmd_i.sat && cmd_i.s == '0) begin
        x0_q <= {sample_re_i, sample_im_i};
      end
      if (!cmd_i.sat && cmd_i.s == CNT_W'(1)) begin
        x1_q <= {sample_re_i, sample_im_i};
      end
    end
    eh_q <= head_edge;
    et_q <= tail_edge;
    ok_q <= age_ok;
    c0_q <= CW'(c0_wide);
  end

  // edge value: a + c0 * (a - b)
  always_comb begin
    if (eh_q) begin
      a_re = x1_q[2*SW-1:SW];
      a_im = x1_q[SW-1:0];
      b_re = x0_q[2*SW-1:SW];
      b_im = x0_q[SW-1:0];
    end else begin
      a_re = age0_q[2*SW-1:SW];
      a_im = age0_q[SW-1:0];
      b_re = age1_q[2*SW-1:SW];
      b_im = age1_q[SW-1:0];
    end
    w_re = win_rd_q[2*SW-1:SW];
    w_im = win_rd_q[SW-1:0];
    d_re = {a_re[SW-1], a_re} - {b_re[SW-1], b_re};
    d_im = {a_im[SW-1], a_im} - {b_im[SW-1], b_im};
    c0s  = {1'b0, c0_q};
    e_re = VW'(a_re) + VW'(c0s) * VW'(d_re);
    e_im = VW'(a_im) + VW'(c0s) * VW'(d_im);
    if (eh_q || et_q) begin
      v_re = e_re;
      v_im = e_im;
    end else if (ok_q) begin
      v_re = VW'(w_re);
      v_im = VW'(w_im);
    end else begin
      v_re = '0;
      v_im = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    v_re_q <= v_re;
    v_im_q <= v_im;
    tap2_q <= tap_rd_q;
    p_re_q <= PW'(v_re_q) * PW'(tap2_q);
    p_im_q <= PW'(v_im_q) * PW'(tap2_q);
    if (cmd_i.clear_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v3_q) begin
      acc_re_q <= acc_re_q + AW'(p_re_q);
      acc_im_q <= acc_im_q + AW'(p_im_q);
    end
    if (cmd_i.load_out) begin
      res_re_q   <= cmd_i.out_zero ? '0 : round_sat(acc_re_q);
      res_im_q   <= cmd_i.out_zero ? '0 : round_sat(acc_im_q);
      res_last_q <= cmd_i.out_last;
      res_err_q  <= cmd_i.out_err;
    end
  end

  assign pipe_busy_o   = v1_q | v2_q | v3_q;
  assign result_re_o   = res_re_q;
  assign result_im_o   = res_im_q;
  assign last_result_o = res_last_q;
  assign error_short_o = res_err_q;

endmodule
`default_nettype wire

// File: sv/cfee_ctrl.sv
// Controller: block bookkeeping, output scheduling and MAC sequencing.
`default_nettype none
module cfee_ctrl #(
  parameter int MAX_TAPS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              command_i,
  input  wire logic                              is_last_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [cfee_pkg::TAPCNT_W-1:0]     cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  input  wire logic                              pipe_busy_i,
  output cfee_pkg::cmd_t                         cmd_o
);
  import cfee_pkg::*;

  state_e                state_q, state_d;
  logic [TAPCNT_W-1:0]   tap_count_q;
  logic [CNT_W-1:0]      s_q, s_d, oc_q, oc_d;
  logic                  last_q, last_d, any_q, any_d, tail_q, tail_d;
  logic                  done_q, done_d, final_q, final_d;
  logic                  zero_q, zero_d, err_q, err_d, out_valid_q, out_valid_d;
  logic [1:0]            n_q, n_d;
  logic [M_W-1:0]        j_q, j_d, k_q, k_d;
  kind_e                 kind_q, kind_d;
  logic [POS_W-1:0]      pos_q, pos_d;

  logic [M_W-1:0]        m, h2, dd, need;
  logic                  sat, short_blk, can;
  logic [POS_W-1:0]      o17, s17, s1;
  logic [1:0]            cap;

  always_comb begin
    if (tap_count_q == '0) begin
      m = M_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      m = M_W'(MAX_TAPS);
    end else begin
      m = M_W'(tap_count_q);
    end
    h2   = m >> 1;
    dd   = m - M_W'(1) - h2;
    need = (m < M_W'(2)) ? M_W'(2) : m;
    sat  = &s_q;
    o17  = {1'b0, oc_q};
    s17  = {1'b0, s_q};
    s1   = s17 + POS_W'(1);
    cap  = last_q ? 2'd1 : 2'd2;
    short_blk = last_q && !sat && (s1 < POS_W'(need));
    can = (n_q < cap) && (o17 + POS_W'(dd) <= s17)
          && !(last_q && (o17 + POS_W'(h2) >= s1))
          && !((o17 < POS_W'(h2)) && (s_q == '0));
  end

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    oc_d        = oc_q;
    last_d      = last_q;
    any_d       = any_q;
    tail_d      = tail_q;
    done_d      = done_q;
    final_d     = final_q;
    zero_d      = zero_q;
    err_d       = err_q;
    n_d         = n_q;
    j_d         = j_q;
    k_d         = k_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    cmd_o           = '0;
    cmd_o.k         = k_q;
    cmd_o.kind      = kind_q;
    cmd_o.pos       = pos_q;
    cmd_o.m         = m;
    cmd_o.h2        = h2;
    cmd_o.s         = s_q;
    cmd_o.sat       = sat;
    cmd_o.out_zero  = zero_q;
    cmd_o.out_last  = final_q;
    cmd_o.out_err   = err_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == CMD_TAP) begin
            cmd_o.tap_we = 1'b1;
          end else begin
            cmd_o.sample_we = 1'b1;
            last_d  = is_last_i;
            n_d     = '0;
            any_d   = 1'b0;
            tail_d  = 1'b0;
            done_d  = 1'b0;
            j_d     = '0;
            k_d     = '0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (short_blk) begin
          zero_d  = 1'b1;
          err_d   = 1'b1;
          final_d = 1'b1;
          done_d  = 1'b1;
          state_d = ST_PUT;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        zero_d = 1'b0;
        err_d  = 1'b0;
        if (sat) begin
          if (n_q == '0 && (!last_q || m[0])) begin
            kind_d  = KIND_MID;
            pos_d   = '0;
            final_d = last_q && (h2 == '0);
            n_d     = n_q + 2'd1;
            any_d   = 1'b1;
            cmd_o.clear_acc = 1'b1;
            state_d = ST_MAC;
          end else begin
            state_d = ST_TAIL;
          end
        end else if (can) begin
          if (o17 < POS_W'(h2)) begin
            kind_d = KIND_HEAD;
            pos_d  = o17;
          end else begin
            kind_d = KIND_MID;
            pos_d  = s17 - (o17 + POS_W'(dd));
          end
          if (oc_q != '1) begin
            oc_d = oc_q + CNT_W'(1);
          end
          final_d = last_q && (h2 == '0);
          n_d     = n_q + 2'd1;
          any_d   = 1'b1;
          cmd_o.clear_acc = 1'b1;
          state_d = ST_MAC;
        end else begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        tail_d = 1'b1;
        zero_d = 1'b0;
        err_d  = 1'b0;
        if (!last_q) begin
          if (!sat) begin
            s_d = s_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end else if (j_q < h2) begin
          kind_d  = KIND_TAIL;
          pos_d   = POS_W'(j_q);
          final_d = (j_q == h2 - M_W'(1));
          j_d     = j_q + M_W'(1);
          any_d   = 1'b1;
          cmd_o.clear_acc = 1'b1;
          state_d = ST_MAC;
        end else if (!any_q) begin
          zero_d  = 1'b1;
          final_d = 1'b1;
          done_d  = 1'b1;
          state_d = ST_PUT;
        end else begin
          s_d     = '0;
          oc_d    = '0;
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (k_q == m - M_W'(1)) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + M_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          if (done_q) begin
            s_d     = '0;
            oc_d    = '0;
            state_d = ST_IDLE;
          end else if (tail_q) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_LOOP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= TAPCNT_W'(1);
      s_q         <= '0;
      oc_q        <= '0;
      last_q      <= 1'b0;
      any_q       <= 1'b0;
      tail_q      <= 1'b0;
      done_q      <= 1'b0;
      final_q     <= 1'b0;
      zero_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      kind_q      <= KIND_HEAD;
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        tap_count_q <= cfg_data_i;
      end
      s_q         <= s_d;
      oc_q        <= oc_d;
      last_q      <= last_d;
      any_q       <= any_d;
      tail_q      <= tail_d;
      done_q      <= done_d;
      final_q     <= final_d;
      zero_q      <= zero_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      j_q         <= j_d;
      k_q         <= k_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: sv/centered_fir_edge_extrapolation_unit.sv
// Top level of the centered FIR edge extrapolation unit.
`default_nettype none
// Centered complex-by-real FIR with output block length equal to input length and
// linearly extrapolated edges. Load taps (command 0, one cycle each), set tap_count,
// then stream samples (command 1) with is_last on the final one. One output is
// computed at a time on a single multiply-accumulate pipeline: each output issues
// its M tap products and then waits for the pipeline to drain before the result
// is loaded into the output register. A sample releases up to two outputs, the final
// sample up to M/2+1 outputs. The next input transfer is taken while the last
// result still waits in the output register. Outputs lag input by M-1-M/2 samples.
module centered_fir_edge_extrapolation_unit #(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               command_i,
  input  wire logic signed [cfee_pkg::TAP_W-1:0]  tap_value_i,
  input  wire logic [cfee_pkg::TIDX_W-1:0]        tap_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_im_i,
  input  wire logic                               is_last_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cfee_pkg::TAPCNT_W-1:0]      cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [cfee_pkg::RES_W-1:0]       result_re_o,
  output logic signed [cfee_pkg::RES_W-1:0]       result_im_o,
  output logic                                    last_result_o,
  output logic                                    error_short_o
);
  import cfee_pkg::*;

  cmd_t cmd;
  logic pipe_busy;

  cfee_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .is_last_i   (is_last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pipe_busy_i (pipe_busy),
    .cmd_o       (cmd)
  );

  cfee_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .tap_value_i   (tap_value_i),
    .tap_index_i   (tap_index_i),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .pipe_busy_o   (pipe_busy),
    .result_re_o   (result_re_o),
    .result_im_o   (result_im_o),
    .last_result_o (last_result_o),
    .error_short_o (error_short_o)
  );

endmodule
`default_nettype wire
